// ===== hdl/variable_latency_word_memory_unit_defines.svh =====
// Assertion macros for the variable latency word memory.
// Used by the top level; no dependencies.
`ifndef VARIABLE_LATENCY_WORD_MEMORY_UNIT_DEFINES_SVH
`define VARIABLE_LATENCY_WORD_MEMORY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define VLWM_CHECK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vlwm check failed");
`define VLWM_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vlwm sequence check failed");
`else
`define VLWM_CHECK(label, prop)
`define VLWM_CHECK_NEXT(label, ante, cons)
`endif

`endif

// ===== hdl/vlwm_pkg.sv =====
// Shared codes, types and byte merge function for the word memory.
// No dependencies.
`default_nettype none

package vlwm_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_RANGE  = 2'd2;

    localparam logic [7:0] BASE_LATENCY_RESET = 8'd4;

    typedef struct packed {
        logic       done;
        logic       rd;
        logic       wr;
        logic [1:0] status;
    } decision_t;

    function automatic logic [31:0] merge_word(
        input logic [31:0] old_word,
        input logic [31:0] new_word,
        input logic [3:0]  be
    );
        logic [31:0] res;
        res = old_word;
        for (int i = 0; i < 4; i++)
        begin
            if (be[i])
            begin
                res[i*8 +: 8] = new_word[i*8 +: 8];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/vlwm_ram.sv =====
// Generic single-clock RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none

module vlwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/vlwm_ctrl.sv =====
// Access state tracker: pending address, direction and countdown, and the
// per-beat decision. Depends on vlwm_pkg.
`default_nettype none

module vlwm_ctrl #(
    parameter int WORD_COUNT = 16384
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire logic [1:0]         command,
    input  wire logic [15:0]        address,
    input  wire logic signed [1:0]  jitter,
    input  wire logic [7:0]         base_latency,
    output vlwm_pkg::decision_t     dec
);

    logic [15:0] pend_addr_reg, pend_addr_next;
    logic        pend_wr_reg,   pend_wr_next;
    logic [7:0]  polls_reg,     polls_next;

    logic              is_write;
    logic              out_of_range;
    logic signed [9:0] load_sum;
    logic [7:0]        load_val;

    assign is_write     = (command == vlwm_pkg::CMD_WRITE);
    assign out_of_range = ({1'b0, address} >= 17'(WORD_COUNT));
    assign load_sum     = $signed({{8{jitter[1]}}, jitter})
                        + $signed({2'b00, base_latency}) - 10'sd1;
    assign load_val     = load_sum[9] ? 8'd0 : load_sum[7:0];

    always_comb
    begin
        dec            = '0;
        pend_addr_next = pend_addr_reg;
        pend_wr_next   = pend_wr_reg;
        polls_next     = polls_reg;
        case (command) inside
            vlwm_pkg::CMD_RESET:
            begin
                polls_next = 8'd0;
            end
            vlwm_pkg::CMD_READ, vlwm_pkg::CMD_WRITE:
            begin
                if (out_of_range)
                begin
                    dec.status = vlwm_pkg::STAT_RANGE;
                end
                else if (polls_reg != 8'd0)
                begin
                    if (pend_addr_reg != address || pend_wr_reg != is_write)
                    begin
                        dec.status = vlwm_pkg::STAT_REJECT;
                    end
                    else
                    begin
                        polls_next = polls_reg - 8'd1;
                        dec.done   = (polls_reg == 8'd1);
                    end
                end
                else if (!is_write && (address == pend_addr_reg ||
                                       address == 16'(pend_addr_reg + 16'd1)))
                begin
                    pend_addr_next = address;
                    dec.done       = 1'b1;
                end
                else
                begin
                    pend_addr_next = address;
                    pend_wr_next   = is_write;
                    polls_next     = load_val;
                    dec.done       = (load_val == 8'd0);
                end
            end
            default:
            begin
            end
        endcase
        dec.rd = dec.done && !is_write;
        dec.wr = dec.done && is_write;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_addr_reg <= 16'hFFFF;
            pend_wr_reg   <= 1'b0;
            polls_reg     <= 8'd0;
        end
        else if (fire)
        begin
            pend_addr_reg <= pend_addr_next;
            pend_wr_reg   <= pend_wr_next;
            polls_reg     <= polls_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/variable_latency_word_memory_unit.sv =====
// Top level of the variable latency word memory: clear sweep, two-stage
// read-merge-write pipeline, output register. Depends on vlwm_pkg,
// vlwm_ram, vlwm_ctrl and the defines header.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  command address write_data byte_enable jitter
//   out      from block out_valid / out_stall done_res read_data status
//   cfg      to block   cfg_valid / cfg_ready cfg_data (base_latency)
//
// One beat per cycle while in_stall is low; a result passes through the b
// stage registers and the output register. The memory's single write port
// and registered read set the pipeline; a write followed at once by a read
// of the same word is forwarded. After reset a sweep writes zero to all
// WORD_COUNT words, one per cycle, with in_stall high. cfg is always ready.
// out_stall holds the pipeline; a new beat still enters while one waits.
`default_nettype none
`include "variable_latency_word_memory_unit_defines.svh"

module variable_latency_word_memory_unit #(
    parameter int WORD_COUNT = 16384
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        command,
    input  wire logic [15:0]       address,
    input  wire logic [31:0]       write_data,
    input  wire logic [3:0]        byte_enable,
    input  wire logic signed [1:0] jitter,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   done_res,
    output logic [31:0]            read_data,
    output logic [1:0]             status,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data
);

    localparam int AW = $clog2(WORD_COUNT);

    localparam logic ST_CLEAR = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    logic          state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [7:0]    base_latency_reg;

    logic                b_valid_reg, b_valid_next;
    vlwm_pkg::decision_t b_dec_reg;
    logic [AW-1:0]       b_addr_reg;
    logic [31:0]         b_data_reg;
    logic [3:0]          b_be_reg;
    logic                b_fwd_reg;
    logic [31:0]         fwd_data_reg;

    logic        out_valid_reg, out_valid_next;
    logic        out_done_reg;
    logic [31:0] out_data_reg;
    logic [1:0]  out_status_reg;

    vlwm_pkg::decision_t dec;
    logic          in_fire;
    logic          b_adv;
    logic          b_write;
    logic          fwd_hit;
    logic [31:0]   ram_rd_data;
    logic [31:0]   rd_eff;
    logic [31:0]   merged;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [31:0]   ram_wr_data;

    assign cfg_ready = 1'b1;

    assign b_adv    = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_RUN) || (b_valid_reg && !b_adv);
    assign in_fire  = in_valid && !in_stall;
    assign b_write  = b_valid_reg && b_adv && b_dec_reg.wr;
    assign fwd_hit  = b_write && (b_addr_reg == address[AW-1:0]);

    assign rd_eff = b_fwd_reg ? fwd_data_reg : ram_rd_data;
    assign merged = vlwm_pkg::merge_word(rd_eff, b_data_reg, b_be_reg);

    vlwm_ctrl #(
        .WORD_COUNT (WORD_COUNT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (in_fire),
        .command      (command),
        .address      (address),
        .jitter       (jitter),
        .base_latency (base_latency_reg),
        .dec          (dec)
    );

    always_comb
    begin
        state_next  = state_reg;
        ram_wr_en   = b_write;
        ram_wr_addr = b_addr_reg;
        ram_wr_data = merged;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                ram_wr_data = 32'd0;
                if (clr_cnt_reg == AW'(WORD_COUNT - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    vlwm_ram #(
        .WIDTH (32),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_fire),
        .rd_addr (address[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        if (in_fire)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_adv)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end
        out_valid_next = b_adv ? b_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            base_latency_reg <= vlwm_pkg::BASE_LATENCY_RESET;
            b_valid_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                base_latency_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            b_dec_reg  <= dec;
            b_addr_reg <= address[AW-1:0];
            b_data_reg <= write_data;
            b_be_reg   <= byte_enable;
            b_fwd_reg  <= fwd_hit;
        end
        if (b_write)
        begin
            fwd_data_reg <= merged;
        end
        if (b_valid_reg && b_adv)
        begin
            out_done_reg   <= b_dec_reg.done;
            out_data_reg   <= b_dec_reg.rd ? rd_eff : 32'd0;
            out_status_reg <= b_dec_reg.status;
        end
    end

    assign out_valid = out_valid_reg;
    assign done_res  = out_done_reg;
    assign read_data = out_data_reg;
    assign status    = out_status_reg;

    `VLWM_CHECK(a_no_beat_in_clear, (state_reg == ST_CLEAR) |-> in_stall)
    `VLWM_CHECK_NEXT(a_beat_reaches_stage, in_fire, b_valid_reg)
    `VLWM_CHECK_NEXT(a_fwd_captured, fwd_hit && in_fire, b_fwd_reg)
    `VLWM_CHECK(a_fail_not_done, out_valid && (status != vlwm_pkg::STAT_OK) |-> !done_res)

endmodule

`default_nettype wire

// ===== test/vlwm_result_checker.sv =====
// Result checker for the variable latency word memory: tracks the memory,
// the pending access and base_latency, and compares each result beat.
// Depends on vlwm_pkg for command and status codes and the base_latency reset value.
module vlwm_result_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        command,
    input  logic [15:0]       address,
    input  logic [31:0]       write_data,
    input  logic [3:0]        byte_enable,
    input  logic signed [1:0] jitter,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              done_res,
    input  logic [31:0]       read_data,
    input  logic [1:0]        status,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    output int                fail_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import vlwm_pkg::*;

    localparam int WORD_COUNT = 16384;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic        done;
        logic [31:0] rdata;
        logic [1:0]  status;
    } poll_result_t;

    logic [31:0]  words [WORD_COUNT];
    logic [15:0]  pend_addr;
    logic         pend_wr;
    logic [7:0]   polls_left;
    logic [7:0]   base_lat;
    poll_result_t expected_results [$];

    function automatic logic [7:0] countdown_load(logic signed [1:0] jit);
        int v;
        v = int'(jit) + int'(base_lat) - 1;
        return (v < 0) ? 8'd0 : v[7:0];
    endfunction

    // Advances the memory state by one poll and returns the result it causes.
    function automatic poll_result_t poll_memory(
        logic [1:0]        op,
        logic [15:0]       addr,
        logic [31:0]       data,
        logic [3:0]        be,
        logic signed [1:0] jit
    );
        poll_result_t r;
        logic         is_wr;
        logic         finish;
        logic [31:0]  w;
        r = '0;
        finish = 1'b0;
        is_wr = (op == CMD_WRITE);
        if (op == CMD_RESET)
        begin
            polls_left = 8'd0;
        end
        else if (op == CMD_READ || op == CMD_WRITE)
        begin
            if (addr >= WORD_COUNT)
            begin
                r.status = STAT_RANGE;
            end
            else if (polls_left != 8'd0)
            begin
                if (pend_addr != addr || pend_wr != is_wr)
                begin
                    r.status = STAT_REJECT;
                end
                else
                begin
                    polls_left = polls_left - 8'd1;
                    finish = (polls_left == 8'd0);
                end
            end
            else if (!is_wr && (addr == pend_addr || addr == 16'(pend_addr + 16'd1)))
            begin
                pend_addr = addr;
                finish = 1'b1;
            end
            else
            begin
                pend_addr = addr;
                pend_wr = is_wr;
                polls_left = countdown_load(jit);
                finish = (polls_left == 8'd0);
            end
            if (finish)
            begin
                r.done = 1'b1;
                if (is_wr)
                begin
                    w = words[addr];
                    for (int i = 0; i < 4; i++)
                    begin
                        if (be[i])
                        begin
                            w[i*8 +: 8] = data[i*8 +: 8];
                        end
                    end
                    words[addr] = w;
                end
                else
                begin
                    r.rdata = words[addr];
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        poll_result_t exp_r;
        poll_result_t new_r;
        if (!rst_n)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                words[i] = '0;
            end
            pend_addr = 16'hFFFF;
            pend_wr = 1'b0;
            polls_left = 8'd0;
            base_lat = BASE_LATENCY_RESET;
            expected_results.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_lat = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                new_r = poll_memory(command, address, write_data, byte_enable, jitter);
                expected_results.insert(expected_results.size(), new_r);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                    begin
                        $display("unexpected result beat: done=%0b data=%h status=%0d",
                                 done_res, read_data, status);
                    end
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (done_res !== exp_r.done || read_data !== exp_r.rdata ||
                        status !== exp_r.status)
                    begin
                        if (fail_count < REPORT_LIMIT)
                        begin
                            $display({"mismatch: expected done=%0b data=%h status=%0d,",
                                      " got done=%0b data=%h status=%0d"},
                                     exp_r.done, exp_r.rdata, exp_r.status,
                                     done_res, read_data, status);
                        end
                        fail_count++;
                    end
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== test/tb_variable_latency_word_memory_unit.sv =====
// Testbench top for the variable latency word memory: clock, reset, poll
// stimulus, base_latency writes and the verdict. Depends on vlwm_pkg,
// the memory top level and vlwm_result_checker.
module tb_variable_latency_word_memory_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import vlwm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 480;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic [1:0]        command = CMD_READ;
    logic [15:0]       address = '0;
    logic [31:0]       write_data = '0;
    logic [3:0]        byte_enable = '0;
    logic signed [1:0] jitter = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [7:0]        cfg_data = '0;
    wire               in_stall;
    wire               out_valid;
    wire               done_res;
    wire [31:0]        read_data;
    wire [1:0]         status;
    wire               cfg_ready;

    int fail_count;
    int outstanding;
    int cycles = 0;
    int items_sent = 0;
    int cur_latency = BASE_LATENCY_RESET;
    int send_idle_pct = 14;
    int recv_idle_pct = 56;

    variable_latency_word_memory_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .address     (address),
        .write_data  (write_data),
        .byte_enable (byte_enable),
        .jitter      (jitter),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .done_res    (done_res),
        .read_data   (read_data),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    vlwm_result_checker memory_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .address     (address),
        .write_data  (write_data),
        .byte_enable (byte_enable),
        .jitter      (jitter),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .done_res    (done_res),
        .read_data   (read_data),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(
        input logic [1:0]        op,
        input logic [15:0]       addr,
        input logic [31:0]       data,
        input logic [3:0]        be,
        input logic signed [1:0] jit
    );
        if (items_sent == PHASE_ITEMS)
        begin
            send_idle_pct <= 56;
            recv_idle_pct <= 14;
        end
        else if (items_sent == 2 * PHASE_ITEMS)
        begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= op;
        address <= addr;
        write_data <= data;
        byte_enable <= be;
        jitter <= jit;
        do
            @(posedge clk);
        while (in_stall);
        if (op != CMD_UNUSED)
        begin
            items_sent++;
        end
    endtask

    function automatic logic [15:0] pick_address();
        int r;
        r = $urandom_range(99);
        if (r < 60)
        begin
            return 16'($urandom_range(15));
        end
        else if (r < 75)
        begin
            return 16'($urandom_range(16383, 16368));
        end
        else if (r < 90)
        begin
            return 16'($urandom_range(16383));
        end
        return 16'($urandom_range(65535, 16384));
    endfunction

    task automatic send_noise();
        send(2'($urandom_range(3)), pick_address(), $urandom, 4'($urandom_range(15)),
             2'($urandom_range(3)));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_latency(input logic [7:0] lat);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= lat;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_latency = lat;
    endtask

    // Mostly complete accesses polled until done, with stray polls mixed in,
    // some accesses abandoned early and usually cleared afterwards.
    task automatic run_random(input int n);
        int                stop_at;
        int                polls;
        int                load;
        logic [1:0]        op;
        logic [15:0]       addr;
        logic signed [1:0] jit;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 12)
            begin
                send_noise();
            end
            else
            begin
                op = $urandom_range(1) ? CMD_WRITE : CMD_READ;
                addr = pick_address();
                jit = 2'($urandom_range(3));
                load = int'(jit) + cur_latency - 1;
                if (load < 0)
                begin
                    load = 0;
                end
                polls = load + 1 + $urandom_range(2);
                if ($urandom_range(9) == 0)
                begin
                    polls = $urandom_range(load + 1, 1);
                end
                for (int i = 0; i < polls; i++)
                begin
                    if ($urandom_range(19) == 0)
                    begin
                        send_noise();
                    end
                    send(op, addr, $urandom, 4'($urandom_range(15)),
                         (i == 0) ? jit : 2'($urandom_range(3)));
                end
                if (polls <= load && $urandom_range(4) != 0)
                begin
                    send(CMD_RESET, pick_address(), $urandom, 4'($urandom_range(15)),
                         2'($urandom_range(3)));
                end
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // base_latency at its reset value of 4
        send(CMD_READ, 16'd0, 32'd0, 4'h0, 2'sd0);
        send(CMD_READ, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, -2'sd1);
        send(CMD_WRITE, 16'd16384, 32'hFFFF_FFFF, 4'hF, 2'sd1);
        send(CMD_WRITE, 16'd16383, 32'hFFFF_FFFF, 4'hF, -2'sd2);
        send(CMD_READ, 16'd16383, 32'd0, 4'h0, 2'sd0);
        send(CMD_WRITE, 16'd16383, 32'hFFFF_FFFF, 4'hF, 2'sd0);
        send(CMD_READ, 16'd16383, 32'd0, 4'h0, 2'sd0);
        send(CMD_WRITE, 16'd7, 32'hA5A5_5A5A, 4'b0101, 2'sd1);
        send(CMD_WRITE, 16'd8, 32'hFFFF_FFFF, 4'hF, 2'sd0);
        send(CMD_RESET, 16'd7, 32'd0, 4'h0, 2'sd0);
        send(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, -2'sd1);
        send(CMD_WRITE, 16'd7, 32'd0, 4'h0, 2'sd0);
        repeat (3) send(CMD_WRITE, 16'd7, 32'h1234_5678, 4'b1010, 2'sd1);
        send(CMD_READ, 16'd7, 32'd0, 4'h0, -2'sd1);
        send(CMD_READ, 16'd9, 32'd0, 4'h0, 2'sd0);
        repeat (3) send(CMD_READ, 16'd9, 32'hFFFF_FFFF, 4'hF, -2'sd2);
        send(CMD_READ, 16'd10, 32'd0, 4'h0, 2'sd0);

        run_random(230);
        set_latency(8'd0);
        run_random(230);
        set_latency(8'd1);
        run_random(230);
        set_latency(8'd255);
        run_random(300);
        set_latency(8'd2);
        run_random(230);
        set_latency(8'($urandom_range(12, 3)));
        run_random(230);

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
